// ----- hw/rtl/lprt_pkg.sv -----
// Shared types, widths and codes for the longest prefix route table.
// Used by the channel interfaces, the route store, the engine and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lprt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int HOP_W    = 32;
   localparam int PORT_W   = 8;
   localparam int METRIC_W = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   localparam logic [LEN_W-1:0]    ADDR_BITS    = 6'd32;
   localparam logic [METRIC_W-1:0] METRIC_LIMIT = 5'd16;

   typedef struct packed {
      logic [ADDR_W-1:0]   prefix;
      logic [LEN_W-1:0]    length;
      logic [HOP_W-1:0]    hop;
      logic [PORT_W-1:0]   port;
      logic [METRIC_W-1:0] metric;
      logic                stale;
   } route_entry_type;

   // Top len bits set; a shift of the full width or more leaves all ones.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage

// ----- hw/rtl/lprt_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on lprt_pkg for field widths.
`timescale 1ns / 1ps

interface lprt_req_if;
   import lprt_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ADDR_W-1:0]   address;
   logic [LEN_W-1:0]    prefix_length;
   logic [HOP_W-1:0]    hop_in;
   logic [PORT_W-1:0]   port_in;
   logic [METRIC_W-1:0] route_metric;
   logic                stale;

   modport source (output valid, kind, address, prefix_length, hop_in, port_in,
                   route_metric, stale, input ready);
   modport sink   (input valid, kind, address, prefix_length, hop_in, port_in,
                   route_metric, stale, output ready);
endinterface

interface lprt_rsp_if;
   import lprt_pkg::*;

   logic              valid;
   logic              ready;
   logic              status;
   logic              found;
   logic [HOP_W-1:0]  hop_out;
   logic [PORT_W-1:0] port_out;

   modport source (output valid, status, found, hop_out, port_out, input ready);
   modport sink   (input valid, status, found, hop_out, port_out, output ready);
endinterface

// ----- hw/rtl/lprt_store.sv -----
// Route entry memory: one write port and one read port, registered read data.
// Depends on lprt_pkg for the entry type.
`timescale 1ns / 1ps

module lprt_store #(
   parameter int TABLE_DEPTH = lprt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_idx,
   input  lprt_pkg::route_entry_type wr_data,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_idx,
   output lprt_pkg::route_entry_type rd_data
);
   import lprt_pkg::*;

   route_entry_type mem [TABLE_DEPTH];
   route_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lprt_engine.sv -----
// Table walker: takes a request word, walks the stored routes through the
// store's read port, writes back and returns one response word.
// Depends on lprt_pkg and the channel interfaces in lprt_if.sv.
`timescale 1ns / 1ps

module lprt_engine #(
   parameter int TABLE_DEPTH = lprt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   lprt_req_if.sink                  req,
   lprt_rsp_if.source                rsp,
   output logic                      wr_en,
   output logic [IDX_W-1:0]          wr_idx,
   output lprt_pkg::route_entry_type wr_data,
   output logic                      rd_en,
   output logic [IDX_W-1:0]          rd_idx,
   input  lprt_pkg::route_entry_type rd_data
);
   import lprt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);

   // Control state.
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Latched request and running result.
   logic [KIND_W-1:0]   kind_ff, kind_in;
   route_entry_type     op_ff, op_in;
   logic [IDX_W-1:0]    data_idx_ff, data_idx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic                status_ff, status_in;
   logic                found_ff, found_in;
   logic [LEN_W-1:0]    best_ff, best_in;
   logic [HOP_W-1:0]    hop_ff, hop_in;
   logic [PORT_W-1:0]   port_ff, port_in;

   // Response register.
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [HOP_W-1:0]    rsp_hop_ff, rsp_hop_in;
   logic [PORT_W-1:0]   rsp_port_ff, rsp_port_in;

   logic issue;
   logic same_route;
   logic live;
   logic covers;

   assign same_route = (rd_data.prefix == op_ff.prefix) && (rd_data.length == op_ff.length);
   assign live       = !rd_data.stale && (rd_data.metric < METRIC_LIMIT);
   assign covers     = ((op_ff.prefix ^ rd_data.prefix) & prefix_mask(rd_data.length)) == '0;
   assign issue      = rd_ptr_ff < used_ff;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      op_in         = op_ff;
      data_idx_in   = data_idx_ff;
      hit_in        = hit_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      hop_in        = hop_ff;
      port_in       = port_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_port_in   = rsp_port_ff;

      rd_en   = 1'b0;
      rd_idx  = rd_ptr_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_idx  = pos_ff;
      wr_data = op_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               kind_in          = req.kind;
               op_in.prefix     = req.address;
               op_in.length     = (req.prefix_length > ADDR_BITS) ? ADDR_BITS
                                                                  : req.prefix_length;
               op_in.hop        = req.hop_in;
               op_in.port       = req.port_in;
               op_in.metric     = (req.route_metric > METRIC_LIMIT) ? METRIC_LIMIT
                                                                    : req.route_metric;
               op_in.stale      = req.stale;
               rd_ptr_in        = '0;
               wr_ptr_in        = '0;
               pend_in          = 1'b0;
               hit_in           = 1'b0;
               status_in        = 1'b0;
               found_in         = 1'b0;
               best_in          = '0;
               hop_in           = '0;
               port_in          = '0;
               state_in         = (req.kind == KIND_NONE) ? ST_HOLD : ST_WALK;
            end
         end
         ST_WALK: begin
            // One read issued per cycle; its data is handled the cycle after.
            if (issue) begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            pend_in     = issue;
            data_idx_in = rd_ptr_ff[IDX_W-1:0];

            if (pend_ff) begin
               case (kind_ff)
                  KIND_INSERT: begin
                     if (same_route && !hit_ff) begin
                        hit_in = 1'b1;
                        pos_in = data_idx_ff;
                     end
                  end
                  KIND_REMOVE: begin
                     // Compaction writes at or below the entry just read, so it
                     // never meets a read still to come.
                     if (!same_route) begin
                        wr_en     = 1'b1;
                        wr_idx    = wr_ptr_ff[IDX_W-1:0];
                        wr_data   = rd_data;
                        wr_ptr_in = wr_ptr_ff + 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     if (live && covers && (!found_ff || rd_data.length > best_ff)) begin
                        found_in = 1'b1;
                        best_in  = rd_data.length;
                        hop_in   = rd_data.hop;
                        port_in  = rd_data.port;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (!issue && !pend_ff) begin
               state_in = ST_HOLD;
               case (kind_ff)
                  KIND_INSERT: begin
                     if (hit_ff) begin
                        wr_en  = 1'b1;
                        wr_idx = pos_ff;
                     end else if (used_ff == DEPTH_COUNT) begin
                        status_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_idx  = used_ff[IDX_W-1:0];
                        used_in = used_ff + 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     used_in = wr_ptr_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_hop_in    = hop_ff;
               rsp_port_in   = port_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      data_idx_ff   <= data_idx_in;
      hit_ff        <= hit_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      hop_ff        <= hop_in;
      port_ff       <= port_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_port_ff   <= rsp_port_in;
   end

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.hop_out  = rsp_hop_ff;
   assign rsp.port_out = rsp_port_ff;

endmodule

// ----- hw/rtl/longest_prefix_route_table_unit.sv -----
// Top level of the longest prefix route table: engine plus route store.
// Depends on lprt_pkg, lprt_if.sv, lprt_store and lprt_engine.
//
//   channel    dir   handshake      word
//   req_port   in    valid/ready    kind, address, prefix_length, hop_in, port_in,
//                                   route_metric, stale
//   rsp_port   out   valid/ready    status, found, hop_out, port_out
//
// Every request but a KIND_NONE word walks the stored routes through the
// store's single read port, one entry a cycle.
// Reset clears the route count and control state, not the stored entries; no entry is read before it has been written.
// A response register sits on the output; a stalled response holds the engine
// after its walk until the register frees, and a request is taken only when idle.
`timescale 1ns / 1ps

module longest_prefix_route_table_unit #(
   parameter int TABLE_DEPTH = lprt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lprt_req_if.sink   req_port,
   lprt_rsp_if.source rsp_port
);
   import lprt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic            wr_en;
   logic [IDX_W-1:0] wr_idx;
   route_entry_type wr_data;
   logic            rd_en;
   logic [IDX_W-1:0] rd_idx;
   route_entry_type rd_data;

   lprt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .req     (req_port),
      .rsp     (rsp_port),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   lprt_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

endmodule

// ----- dv/longest_prefix_route_table_unit_test.sv -----
// Self-checking testbench for longest_prefix_route_table_unit: predicts every reply word
// from its own route table and checks each one as it leaves the block.
// Depends on lprt_pkg, the channel interfaces in lprt_if.sv and the RTL top level.
`timescale 1ns / 1ps

module longest_prefix_route_table_unit_test;
   import lprt_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int POOL_SIZE   = 20;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    prefix_length;
      logic [HOP_W-1:0]    hop_in;
      logic [PORT_W-1:0]   port_in;
      logic [METRIC_W-1:0] route_metric;
      logic                stale;
   } route_cmd_type;

   typedef struct packed {
      logic              status;
      logic              found;
      logic [HOP_W-1:0]  hop;
      logic [PORT_W-1:0] port;
   } route_reply_type;

   logic clock;
   logic reset;

   lprt_req_if req_bus ();
   lprt_rsp_if rsp_bus ();

   longest_prefix_route_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow route table, kept in age order like the block's own store.
   route_entry_type   route_slot [TABLE_DEPTH];
   int                route_count = 0;
   route_reply_type   pending_replies [$];
   int                error_count = 0;
   bit                sender_steady = 1'b0;
   bit                receiver_steady = 1'b0;
   int                reply_stall = 0;
   int                reply_hold = 0;
   logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
   logic [LEN_W-1:0]  pool_len [POOL_SIZE];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [ADDR_W-1:0] route_mask(input logic [LEN_W-1:0] len);
      if (len == 0)
         return '0;
      return {ADDR_W{1'b1}} << (int'(ADDR_BITS) - int'(len));
   endfunction

   // Applies one request word to the shadow table and returns the reply it must produce.
   function automatic route_reply_type apply_route_word(input route_cmd_type w);
      route_reply_type     reply;
      logic [LEN_W-1:0]    len;
      logic [METRIC_W-1:0] metric;
      logic [LEN_W-1:0]    best_len;
      logic [ADDR_W-1:0]   mask;
      int                  pos;
      int                  keep;
      reply    = '0;
      best_len = '0;
      len      = (w.prefix_length > ADDR_BITS) ? ADDR_BITS : w.prefix_length;
      metric   = (w.route_metric > METRIC_LIMIT) ? METRIC_LIMIT : w.route_metric;
      case (w.kind)
         KIND_INSERT: begin
            pos = route_count;
            for (int i = 0; i < route_count; i++) begin
               if (route_slot[i].prefix == w.address && route_slot[i].length == len) begin
                  pos = i;
                  break;
               end
            end
            if (pos == route_count && route_count >= TABLE_DEPTH) begin
               reply.status = 1'b1;
            end else begin
               if (pos == route_count)
                  route_count++;
               route_slot[pos] = '{prefix: w.address, length: len, hop: w.hop_in,
                                   port: w.port_in, metric: metric, stale: w.stale};
            end
         end
         KIND_REMOVE: begin
            keep = 0;
            for (int i = 0; i < route_count; i++) begin
               if (!(route_slot[i].prefix == w.address && route_slot[i].length == len)) begin
                  route_slot[keep] = route_slot[i];
                  keep++;
               end
            end
            route_count = keep;
         end
         KIND_QUERY: begin
            for (int i = 0; i < route_count; i++) begin
               if (!route_slot[i].stale && route_slot[i].metric < METRIC_LIMIT) begin
                  mask = route_mask(route_slot[i].length);
                  if ((w.address & mask) == (route_slot[i].prefix & mask) &&
                      (!reply.found || route_slot[i].length > best_len)) begin
                     reply.found = 1'b1;
                     best_len    = route_slot[i].length;
                     reply.hop   = route_slot[i].hop;
                     reply.port  = route_slot[i].port;
                  end
               end
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   function automatic route_cmd_type make_word(input logic [KIND_W-1:0] kind,
                                               input logic [ADDR_W-1:0] address,
                                               input logic [LEN_W-1:0] prefix_length,
                                               input logic [HOP_W-1:0] hop_in,
                                               input logic [PORT_W-1:0] port_in,
                                               input logic [METRIC_W-1:0] route_metric,
                                               input logic stale);
      route_cmd_type w;
      w = '{kind: kind, address: address, prefix_length: prefix_length, hop_in: hop_in,
            port_in: port_in, route_metric: route_metric, stale: stale};
      return w;
   endfunction

   // Builds prefixes around a few shared roots so that queries hit nested routes.
   function automatic void refresh_route_pool();
      logic [ADDR_W-1:0] roots [3];
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] mask;
      int                r;
      foreach (roots[k])
         roots[k] = $urandom;
      for (int k = 0; k < POOL_SIZE; k++) begin
         r    = $urandom_range(0, 2);
         len  = ($urandom_range(0, 3) == 0) ? LEN_W'(8 * $urandom_range(0, 4))
                                            : LEN_W'($urandom_range(0, 32));
         mask = route_mask(len);
         pool_len[k]  = len;
         pool_addr[k] = ($urandom_range(0, 2) == 0) ? ((roots[r] & mask) | ($urandom & ~mask))
                                                    : (roots[r] & mask);
      end
   endfunction

   function automatic route_cmd_type random_word();
      route_cmd_type     w;
      logic [ADDR_W-1:0] mask;
      int                pick;
      int                p;
      pick = $urandom_range(0, 99);
      p    = $urandom_range(0, POOL_SIZE - 1);
      w.hop_in        = $urandom;
      w.port_in       = PORT_W'($urandom);
      w.route_metric  = ($urandom_range(0, 7) == 0) ? METRIC_W'($urandom_range(16, 31))
                                                    : METRIC_W'($urandom_range(0, 15));
      w.stale         = ($urandom_range(0, 7) == 0);
      w.address       = pool_addr[p];
      w.prefix_length = pool_len[p];
      if (pool_len[p] == ADDR_BITS && $urandom_range(0, 3) == 0)
         w.prefix_length = LEN_W'($urandom_range(33, 63));
      if (pick < 40) begin
         w.kind = KIND_INSERT;
      end else if (pick < 55) begin
         w.kind = KIND_REMOVE;
      end else if (pick < 92) begin
         w.kind          = KIND_QUERY;
         mask            = route_mask(pool_len[p]);
         w.address       = (pool_addr[p] & mask) | ($urandom & ~mask);
         if ($urandom_range(0, 9) == 0)
            w.address = $urandom;
         w.prefix_length = LEN_W'($urandom_range(0, 63));
      end else begin
         w.kind          = KIND_W'($urandom_range(0, 3));
         w.address       = $urandom;
         w.prefix_length = LEN_W'($urandom_range(0, 63));
         w.route_metric  = METRIC_W'($urandom_range(0, 31));
      end
      return w;
   endfunction

   // Valid stays high between back-to-back words; it only drops for a gap or a pause.
   task automatic send_word(input route_cmd_type w);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.kind          = w.kind;
      req_bus.address       = w.address;
      req_bus.prefix_length = w.prefix_length;
      req_bus.hop_in        = w.hop_in;
      req_bus.port_in       = w.port_in;
      req_bus.route_metric  = w.route_metric;
      req_bus.stale         = w.stale;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_replies.push_back(apply_route_word(w));
   endtask

   task automatic pause_until_replied();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic clear_table();
      while (route_count > 0)
         send_word(make_word(KIND_REMOVE, route_slot[0].prefix, route_slot[0].length,
                             $urandom, 8'd0, 5'd0, 1'b0));
   endtask

   task automatic test_directed_routes();
      send_word(make_word(KIND_QUERY,  32'h0808_0808, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0000_0000, 6'd0,  32'hC0A8_0001, 8'd1,   5'd1,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A00_0000, 6'd8,  32'hC0A8_0002, 8'd2,   5'd0,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A01_0000, 6'd16, 32'hC0A8_0003, 8'd3,   5'd15, 1'b0));
      // Host bits below the length are kept and matter for replace and remove only.
      send_word(make_word(KIND_INSERT, 32'h0A01_024D, 6'd24, 32'hC0A8_0004, 8'd4,   5'd2,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A01_0203, 6'd40, 32'hFFFF_FFFF, 8'hFF,  5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_0203, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_02C8, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_0909, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0AC8_0000, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'hFFFF_FFFF, 6'd63, 32'h0,         8'd0,   5'd0,  1'b0));
      // A /32 written as an over-long length is replaced here with an unreachable metric.
      send_word(make_word(KIND_INSERT, 32'h0A01_0203, 6'd32, 32'hC0A8_0005, 8'd5,   5'd20, 1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_0203, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A01_0000, 6'd16, 32'hC0A8_0006, 8'd6,   5'd1,  1'b1));
      send_word(make_word(KIND_QUERY,  32'h0A01_0909, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A01_0001, 6'd16, 32'hC0A8_0007, 8'd7,   5'd16, 1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A01_0002, 6'd16, 32'hC0A8_0008, 8'd8,   5'd3,  1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A01_0003, 6'd16, 32'hC0A8_0009, 8'd9,   5'd3,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_0909, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_REMOVE, 32'h0A01_0200, 6'd24, 32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_02C8, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_REMOVE, 32'h0A01_024D, 6'd24, 32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A01_02C8, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_NONE,   32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF,  5'h1F, 1'b1));
      send_word(make_word(KIND_REMOVE, 32'h0000_0000, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
      send_word(make_word(KIND_QUERY,  32'h0B00_0000, 6'd0,  32'h0,         8'd0,   5'd0,  1'b0));
   endtask

   task automatic test_full_table();
      clear_table();
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_word(make_word(KIND_INSERT, 32'h0A00_0000 | (ADDR_W'(i) << 8), 6'd24, $urandom,
                             PORT_W'(i), METRIC_W'($urandom_range(0, 15)), 1'b0));
      send_word(make_word(KIND_INSERT, 32'h0AC8_0000, 6'd24, 32'h1234_5678, 8'd1, 5'd0, 1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A00_0509, 6'd0,  32'h0, 8'd0, 5'd0, 1'b0));
      // Replacing an existing route must still work with every slot taken.
      send_word(make_word(KIND_INSERT, 32'h0A00_0500, 6'd24, 32'h8765_4321, 8'd77, 5'd4, 1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A00_0509, 6'd0,  32'h0, 8'd0, 5'd0, 1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A00_0000, 6'd16, 32'hAAAA_5555, 8'd99, 5'd0, 1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A00_3F01, 6'd0,  32'h0, 8'd0, 5'd0, 1'b0));
      send_word(make_word(KIND_REMOVE, 32'h0A00_0700, 6'd24, 32'h0, 8'd0, 5'd0, 1'b0));
      send_word(make_word(KIND_INSERT, 32'h0A00_0000, 6'd16, 32'hAAAA_5555, 8'd99, 5'd0, 1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A00_0701, 6'd0,  32'h0, 8'd0, 5'd0, 1'b0));
      send_word(make_word(KIND_QUERY,  32'h0A00_0801, 6'd0,  32'h0, 8'd0, 5'd0, 1'b0));
      send_word(make_word(KIND_INSERT, 32'h0AC9_0000, 6'd24, 32'h1234_5678, 8'd1, 5'd0, 1'b0));
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      pause_until_replied();
      sender_steady = 1'b1;
      reply_hold    = 300;
      repeat (12) send_word(random_word());
      sender_steady = 1'b0;
      pause_until_replied();
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 400 == 0) begin
            refresh_route_pool();
            if (route_count > 48)
               clear_table();
         end
         if (n % 100 == 0) begin
            sender_steady   = ($urandom_range(0, 4) == 0);
            receiver_steady = ($urandom_range(0, 4) == 0);
         end
         send_word(random_word());
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reply_hold > 0) begin
            rsp_bus.ready = 1'b0;
            reply_hold--;
         end else if (reply_stall > 0) begin
            rsp_bus.ready = 1'b0;
            reply_stall--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : reply_check
      route_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $error("reply word with none pending: status %0d found %0d hop %0h port %0h",
                   rsp_bus.status, rsp_bus.found, rsp_bus.hop_out, rsp_bus.port_out);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("status",   32'(want.status), 32'(rsp_bus.status));
            check_field("found",    32'(want.found),  32'(rsp_bus.found));
            check_field("hop_out",  want.hop,         rsp_bus.hop_out);
            check_field("port_out", 32'(want.port),   32'(rsp_bus.port_out));
         end
         reply_stall = receiver_steady ? 0 : $urandom_range(0, 10);
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.kind          = '0;
      req_bus.address       = '0;
      req_bus.prefix_length = '0;
      req_bus.hop_in        = '0;
      req_bus.port_in       = '0;
      req_bus.route_metric  = '0;
      req_bus.stale         = 1'b0;
      refresh_route_pool();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_routes();
      test_full_table();
      test_backpressure();
      test_random_traffic(1900);

      pause_until_replied();
      repeat (TABLE_DEPTH + 10) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/lprt_pkg.sv
hw/rtl/lprt_if.sv
hw/rtl/lprt_store.sv
hw/rtl/lprt_engine.sv
hw/rtl/longest_prefix_route_table_unit.sv
dv/longest_prefix_route_table_unit_test.sv
